FILE: rtl/mss_pkg.sv
`timescale 1ns / 1ps
// mss_pkg: types, codes and helpers shared by the mission start sequencer.
// No dependencies.
package mss_pkg;

  // Action codes (tuser on the input stream)
  localparam logic [1:0] ACT_TICK  = 2'd0;
  localparam logic [1:0] ACT_START = 2'd1;
  localparam logic [1:0] ACT_ABORT = 2'd2;
  localparam logic [1:0] ACT_PART  = 2'd3;

  // Status codes
  localparam logic [2:0] ST_OK         = 3'd0;
  localparam logic [2:0] ST_INVALID    = 3'd1;
  localparam logic [2:0] ST_NO_MISSION = 3'd2;
  localparam logic [2:0] ST_MISMATCH   = 3'd3;
  localparam logic [2:0] ST_NOT_READY  = 3'd4;

  // Event kinds (tuser on the output stream)
  localparam logic [1:0] EV_NONE     = 2'd0;
  localparam logic [1:0] EV_COMPLETE = 2'd1;
  localparam logic [1:0] EV_ABORTED  = 2'd2;

  // Register map
  localparam int unsigned     AddrW        = 3;
  localparam logic            REG_SETTLE   = 1'b0;
  localparam logic            REG_TIMEOUT  = 1'b1;
  localparam logic [15:0]     SettleReset  = 16'd200;
  localparam logic [15:0]     TimeoutReset = 16'd1500;

  typedef struct packed {
    logic [1:0]  action;
    logic [31:0] now_ms;
    logic        pose_valid;
    logic [7:0]  branch_num;
    logic        id_present;
    logic        mission_active;
    logic        id_matches;
    logic        transfer_done;
    logic        bypass_mode;
    logic        correction_sent;
    logic [3:0]  stop_reason;
    logic [15:0] parts_total;
  } item_t;

  typedef struct packed {
    logic        run;
    logic        pend;
    logic        moved;
    logic        started;
    logic [15:0] part;
    logic [7:0]  armed_branch;
    logic [31:0] armed_time;
    logic [31:0] moved_time;
  } seq_t;

  typedef struct packed {
    logic [2:0]  status;
    logic        accepted;
    logic        running;
    logic        start_waiting;
    logic        just_started;
    logic [15:0] part_index;
    logic [1:0]  event_kind;
    logic [15:0] event_part;
    logic [15:0] event_count;
    logic [3:0]  event_reason;
  } res_t;

  // Clears the pending-start bookkeeping
  function automatic seq_t drop_pending(seq_t s);
    seq_t r;
    r              = s;
    r.pend         = 1'b0;
    r.moved        = 1'b0;
    r.armed_branch = '0;
    r.armed_time   = '0;
    r.moved_time   = '0;
    return r;
  endfunction

  function automatic seq_t go_running(seq_t s);
    seq_t r;
    r         = drop_pending(s);
    r.run     = 1'b1;
    r.started = 1'b1;
    r.part    = '0;
    return r;
  endfunction

endpackage

FILE: rtl/mss_cfg.sv
`timescale 1ns / 1ps
// mss_cfg: APB register file holding settle time and start timeout.
// Depends on mss_pkg.
module mss_cfg (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  logic                     psel,
  input  logic                     penable,
  input  logic                     pwrite,
  input  logic [mss_pkg::AddrW-1:0] paddr,
  input  logic [31:0]              pwdata,
  output logic [31:0]              prdata,
  output logic                     pready,
  output logic [15:0]              settle_o,
  output logic [15:0]              timeout_o
);
  import mss_pkg::*;

  logic [15:0] settle_q, timeout_q;
  logic        wr_en;

  assign pready = 1'b1;
  assign wr_en  = psel & penable & pwrite & pready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      settle_q  <= SettleReset;
      timeout_q <= TimeoutReset;
    end else if (wr_en) begin
      unique case (paddr[2])
        REG_SETTLE:  settle_q  <= pwdata[15:0];
        REG_TIMEOUT: timeout_q <= pwdata[15:0];
        default:     settle_q  <= settle_q;
      endcase
    end
  end

  always_comb begin
    unique case (paddr[2])
      REG_SETTLE:  prdata = {16'd0, settle_q};
      REG_TIMEOUT: prdata = {16'd0, timeout_q};
      default:     prdata = '0;
    endcase
  end

  assign settle_o  = settle_q;
  assign timeout_o = timeout_q;

endmodule

FILE: rtl/mss_step.sv
`timescale 1ns / 1ps
// mss_step: next-state and result logic for one event.
// Depends on mss_pkg.
module mss_step (
  input  mss_pkg::item_t item_i,
  input  mss_pkg::seq_t  st_i,
  input  logic [15:0]    settle_i,
  input  logic [15:0]    timeout_i,
  output mss_pkg::seq_t  st_o,
  output mss_pkg::res_t  res_o
);
  import mss_pkg::*;

  logic [31:0] el_arm, el_mov;
  logic        arm_due, mov_due;
  logic [16:0] part_nxt;

  // wrapping elapsed time since arming / since branch change
  assign el_arm   = item_i.now_ms - st_i.armed_time;
  assign el_mov   = item_i.now_ms - st_i.moved_time;
  assign arm_due  = el_arm >= {16'd0, timeout_i};
  assign mov_due  = el_mov >= {16'd0, settle_i};
  assign part_nxt = {1'b0, st_i.part} + 17'd1;

  always_comb begin
    seq_t s;
    res_t r;
    s = st_i;
    r = '0;
    unique case (item_i.action)
      ACT_TICK: begin
        s.started = 1'b0;
        if (st_i.pend) begin
          if (!item_i.pose_valid) begin
            if (arm_due) s = drop_pending(s);
          end else if (!st_i.moved) begin
            if (item_i.branch_num != st_i.armed_branch) begin
              s.moved      = 1'b1;
              s.moved_time = item_i.now_ms;
            end else if (arm_due) begin
              s = go_running(s);
            end
          end else if (mov_due) begin
            s = go_running(s);
          end
        end
      end
      ACT_START: begin
        if (!item_i.id_present)          r.status = ST_INVALID;
        else if (!item_i.mission_active) r.status = ST_NO_MISSION;
        else if (!item_i.id_matches)     r.status = ST_MISMATCH;
        else if (!item_i.transfer_done)  r.status = ST_NOT_READY;
        else if (!item_i.pose_valid)     r.status = ST_NOT_READY;
        else if (item_i.bypass_mode)     s = go_running(s);
        else if (!item_i.correction_sent) r.status = ST_NOT_READY;
        else begin
          s.run          = 1'b0;
          s.part         = '0;
          s.pend         = 1'b1;
          s.moved        = 1'b0;
          s.armed_branch = item_i.branch_num;
          s.armed_time   = item_i.now_ms;
          s.moved_time   = '0;
        end
      end
      ACT_ABORT: begin
        if (!item_i.mission_active) begin
          r.status = ST_NO_MISSION;
        end else begin
          r.event_kind   = EV_ABORTED;
          r.event_part   = st_i.part;
          r.event_count  = item_i.parts_total;
          r.event_reason = item_i.stop_reason;
          s              = drop_pending(s);
          s.run          = 1'b0;
          s.part         = '0;
        end
      end
      ACT_PART: begin
        if (st_i.run) begin
          r.accepted = 1'b1;
          if (item_i.parts_total == 16'd0) begin
            s.run        = 1'b0;
            s.part       = '0;
            r.event_kind = EV_COMPLETE;
          end else if (part_nxt < {1'b0, item_i.parts_total}) begin
            s.part = part_nxt[15:0];
          end else begin
            // last part: index stays where it is and is reported
            s.run         = 1'b0;
            r.event_kind  = EV_COMPLETE;
            r.event_part  = st_i.part;
            r.event_count = item_i.parts_total;
          end
        end
      end
      default: s = st_i;
    endcase
    r.running       = s.run;
    r.start_waiting = s.pend;
    r.just_started  = s.started;
    r.part_index    = s.part;
    st_o  = s;
    res_o = r;
  end

endmodule

FILE: rtl/mission_start_sequencer.sv
`timescale 1ns / 1ps
// mission_start_sequencer: top level of the mission run sequencer.
// Depends on mss_pkg, mss_cfg and mss_step.

// Sequences the start, run and end of a mission from a stream of events
// (tick, start, abort, complete-part), one result per event. An event is
// registered on input, evaluated against the sequencer state in
// combinational logic, and its result lands in an output register; the
// state is updated together with the output register, so every event
// sees the effect of the one before it. Throughput is one event per clock
// while the output is not stalled. The input register can take one event
// while a result waits in the output register; the input stage holds when
// it is full and the output register is full and not being drained.
// settle_time_ms (0x0) and start_timeout_ms (0x4) sit on the APB port and
// must only be written while no event is in flight.
module mission_start_sequencer (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  // input events
  input  logic                      s_axis_tvalid,
  output logic                      s_axis_tready,
  // now_ms[31:0], pose_valid[32], branch_num[40:33], id_present[41],
  // mission_active[42], id_matches[43], transfer_done[44], bypass_mode[45],
  // correction_sent[46], stop_reason[50:47], parts_total[66:51], zero[71:67]
  input  logic [71:0]               s_axis_tdata,
  // action[1:0]
  input  logic [1:0]                s_axis_tuser,
  // results
  output logic                      m_axis_tvalid,
  input  logic                      m_axis_tready,
  // status[2:0], accepted[3], running[4], start_waiting[5], just_started[6],
  // part_index[22:7], event_part[38:23], event_count[54:39],
  // event_reason[58:55], zero[63:59]
  output logic [63:0]               m_axis_tdata,
  // event_kind[1:0]
  output logic [1:0]                m_axis_tuser,
  // configuration
  input  logic                      psel,
  input  logic                      penable,
  input  logic                      pwrite,
  input  logic [mss_pkg::AddrW-1:0] paddr,
  input  logic [31:0]               pwdata,
  output logic [31:0]               prdata,
  output logic                      pready
);
  import mss_pkg::*;

  logic [15:0] settle, timeout;

  // input stage
  logic  in_valid_q;
  item_t in_item_q;
  item_t in_item;

  // output stage
  logic  out_valid_q;
  res_t  out_res_q;

  // sequencer state
  seq_t  st_q, st_d;
  res_t  res_d;

  logic  adv;       // event moves from input register to output register
  logic  s_xfer;

  mss_cfg u_cfg (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .psel      (psel),
    .penable   (penable),
    .pwrite    (pwrite),
    .paddr     (paddr),
    .pwdata    (pwdata),
    .prdata    (prdata),
    .pready    (pready),
    .settle_o  (settle),
    .timeout_o (timeout)
  );

  mss_step u_step (
    .item_i    (in_item_q),
    .st_i      (st_q),
    .settle_i  (settle),
    .timeout_i (timeout),
    .st_o      (st_d),
    .res_o     (res_d)
  );

  // unpack the input transfer
  assign in_item.action          = s_axis_tuser;
  assign in_item.now_ms          = s_axis_tdata[31:0];
  assign in_item.pose_valid      = s_axis_tdata[32];
  assign in_item.branch_num      = s_axis_tdata[40:33];
  assign in_item.id_present      = s_axis_tdata[41];
  assign in_item.mission_active  = s_axis_tdata[42];
  assign in_item.id_matches      = s_axis_tdata[43];
  assign in_item.transfer_done   = s_axis_tdata[44];
  assign in_item.bypass_mode     = s_axis_tdata[45];
  assign in_item.correction_sent = s_axis_tdata[46];
  assign in_item.stop_reason     = s_axis_tdata[50:47];
  assign in_item.parts_total     = s_axis_tdata[66:51];

  // handshake: output slot free or draining lets the input stage advance
  assign adv           = in_valid_q & (~out_valid_q | m_axis_tready);
  assign s_axis_tready = ~in_valid_q | adv;
  assign s_xfer        = s_axis_tvalid & s_axis_tready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else if (s_axis_tready) begin
      in_valid_q <= s_axis_tvalid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s_xfer) begin
      in_item_q <= in_item;
    end
  end

  // state only moves when the event it belongs to is committed
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q <= '0;
    end else if (adv) begin
      st_q <= st_d;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (adv) begin
      out_valid_q <= 1'b1;
    end else if (m_axis_tready) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      out_res_q <= res_d;
    end
  end

  // pack the result transfer
  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tuser  = out_res_q.event_kind;
  assign m_axis_tdata  = {5'd0,
                          out_res_q.event_reason,
                          out_res_q.event_count,
                          out_res_q.event_part,
                          out_res_q.part_index,
                          out_res_q.just_started,
                          out_res_q.start_waiting,
                          out_res_q.running,
                          out_res_q.accepted,
                          out_res_q.status};

`ifndef SYNTHESIS
  // running and a pending start exclude each other
  a_run_xor_pend: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(st_q.run && st_q.pend))
    else $error("run and pending start both set");

  // a branch change is only tracked while a start is pending
  a_moved_pend: assert property (@(posedge clk_i) disable iff (!rst_ni)
    st_q.moved |-> st_q.pend)
    else $error("branch moved without pending start");

  // an aborted event always leaves the sequencer idle
  a_abort_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid && m_axis_tuser == EV_ABORTED) |->
      (!m_axis_tdata[4] && !m_axis_tdata[5] && m_axis_tdata[22:7] == 16'd0))
    else $error("aborted event with live state");

  // a committed event updates the output register on the next edge
  a_commit: assert property (@(posedge clk_i) disable iff (!rst_ni)
    adv |=> out_valid_q)
    else $error("committed event lost");
`endif

endmodule
